[rtl/timer_deadline_heap_unit_macros.svh]
// assertion macros for the timer deadline heap unit
`ifndef TIMER_DEADLINE_HEAP_UNIT_MACROS_SVH
`define TIMER_DEADLINE_HEAP_UNIT_MACROS_SVH

// implication checked on every clock edge outside reset
`define TDH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tdh check failed");

// implication whose consequent is checked in the cycle after the antecedent
`define TDH_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tdh check failed");

`endif

[rtl/tdh_pkg.sv]
// ----------------------------------------------------------------------------
// tdh_pkg
// types, constants and codes shared by the timer deadline heap unit
// ----------------------------------------------------------------------------
`default_nettype none
package tdh_pkg;
    localparam int QUEUE_DEPTH = 64;
    localparam int TAG_BITS    = 16;
    localparam int MAX_RESULTS = 64;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);
    localparam int TIME_W      = 52;
    localparam int DELAY_W     = 40;
    localparam int TV_W        = 53;
    localparam int TAGF_W      = 16;
    localparam int ENTRY_W     = TIME_W + TAG_BITS;

    typedef logic [1:0] t_op;
    localparam t_op OP_INSERT = 2'd0;
    localparam t_op OP_EXPIRE = 2'd1;
    localparam t_op OP_REMOVE = 2'd2;
    localparam t_op OP_PEEK   = 2'd3;

    typedef logic [2:0] t_status;
    localparam t_status ST_DONE    = 3'd0;
    localparam t_status ST_EXPIRED = 3'd1;
    localparam t_status ST_NOTAG   = 3'd2;
    localparam t_status ST_FULL    = 3'd3;
    localparam t_status ST_NONE    = 3'd4;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_UP_RD,
        S_UP_WAIT,
        S_UP_CMP,
        S_UP_SIB_RD,
        S_UP_SIB_WAIT,
        S_UP_SIB_CMP,
        S_DN_RD,
        S_DN_WAIT,
        S_DN_CMP,
        S_DN_CMP2,
        S_EXP_RD,
        S_EXP_WAIT,
        S_EXP_CHK,
        S_EXP_LAST_WAIT,
        S_SCAN_RD,
        S_SCAN_WAIT,
        S_SCAN_CHK,
        S_REM_LAST_WAIT,
        S_REM_FILL,
        S_PEEK_WAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [TIME_W-1:0]   deadline;
        logic [TAG_BITS-1:0] tag;
    } t_entry;
endpackage
`default_nettype wire

[rtl/tdh_ram.sv]
// ----------------------------------------------------------------------------
// tdh_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module tdh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

[rtl/tdh_ctrl.sv]
// ----------------------------------------------------------------------------
// tdh_ctrl
// sequencer for heap operations over a single ram port and one comparator
// ----------------------------------------------------------------------------
`default_nettype none
module tdh_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [1:0]                    i_opcode,
    input  wire logic [tdh_pkg::TAGF_W-1:0]    i_tag,
    input  wire logic [tdh_pkg::DELAY_W-1:0]   i_delay_us,
    input  wire logic [tdh_pkg::TIME_W-1:0]    i_now_us,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [2:0]                         o_status,
    output logic [tdh_pkg::TAGF_W-1:0]         o_tag_out,
    output logic signed [tdh_pkg::TV_W-1:0]    o_time_value,
    output logic                               o_last,
    output logic                               o_we,
    output logic [tdh_pkg::ADDR_W-1:0]         o_addr,
    output tdh_pkg::t_entry                    o_wdata,
    input  wire tdh_pkg::t_entry               i_rdata
);
    import tdh_pkg::*;

    t_state               r_state, n_state;
    t_op                  r_op, n_op;
    logic [TAG_BITS-1:0]  r_tag, n_tag;
    logic [TIME_W-1:0]    r_now, n_now;
    logic [TIME_W:0]      r_sum, n_sum;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [ADDR_W-1:0]    r_pos, n_pos;
    logic [ADDR_W-1:0]    r_from, n_from;
    logic [ADDR_W:0]      r_child, n_child;
    logic                 r_swapped, n_swapped;
    logic                 r_up_only, n_up_only;
    logic                 r_after_exp, n_after_exp;
    t_entry               r_cur, n_cur;
    t_entry               r_oth, n_oth;
    logic [ADDR_W-1:0]    r_oth_idx, n_oth_idx;
    logic [RES_W-1:0]     r_nres, n_nres;
    logic [TAG_BITS-1:0]  r_ptag, n_ptag;
    logic                 r_ov, n_ov;
    logic [2:0]           r_st, n_st;
    logic [TAGF_W-1:0]    r_ot, n_ot;
    logic [TV_W-1:0]      r_tv, n_tv;
    logic                 r_ol, n_ol;

    logic [ADDR_W-1:0]    w_par;
    logic [ADDR_W+1:0]    w_lc;
    logic [TIME_W-1:0]    w_cmp_a, w_cmp_b;
    logic                 w_lt;

    assign w_par = (r_pos - ADDR_W'(1)) >> 1;
    assign w_lc  = {1'b0, r_pos, 1'b1};

    // operand select for the shared deadline comparator
    always_comb begin
        w_cmp_a = r_cur.deadline;
        w_cmp_b = r_oth.deadline;
        case (r_state)
            S_UP_SIB_CMP: begin
                w_cmp_a = i_rdata.deadline;
                w_cmp_b = r_cur.deadline;
            end
            S_DN_CMP2: w_cmp_a = i_rdata.deadline;
            S_EXP_CHK: w_cmp_a = r_now;
            default: ;
        endcase
    end

    assign w_lt = (w_cmp_a < w_cmp_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
        end
        r_op <= n_op; r_tag <= n_tag; r_now <= n_now; r_sum <= n_sum;
        r_pos <= n_pos; r_from <= n_from; r_child <= n_child;
        r_swapped <= n_swapped; r_up_only <= n_up_only; r_after_exp <= n_after_exp;
        r_cur <= n_cur; r_oth <= n_oth; r_oth_idx <= n_oth_idx; r_nres <= n_nres;
        r_ptag <= n_ptag;
        r_st <= n_st; r_ot <= n_ot; r_tv <= n_tv; r_ol <= n_ol;
    end

    // a result still waiting in the output register holds off the next item
    assign o_stall      = (r_state != S_IDLE) || r_ov;
    assign o_valid      = r_ov;
    assign o_status     = r_st;
    assign o_tag_out    = r_ot;
    assign o_time_value = r_tv;
    assign o_last       = r_ol;

    always_comb begin
        n_state = r_state; n_op = r_op; n_tag = r_tag; n_now = r_now; n_sum = r_sum;
        n_cnt = r_cnt; n_pos = r_pos; n_from = r_from; n_child = r_child;
        n_swapped = r_swapped; n_up_only = r_up_only; n_after_exp = r_after_exp;
        n_cur = r_cur; n_oth = r_oth; n_oth_idx = r_oth_idx; n_nres = r_nres;
        n_ptag = r_ptag;
        n_ov = r_ov; n_st = r_st; n_ot = r_ot; n_tv = r_tv; n_ol = r_ol;
        o_we = 1'b0; o_addr = r_pos; o_wdata = r_cur;
        if (r_ov && !i_stall) begin
            n_ov = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && !r_ov) begin
                    n_op  = t_op'(i_opcode);
                    n_tag = i_tag[TAG_BITS-1:0];
                    n_now = i_now_us;
                    n_sum = {1'b0, i_now_us} + (TIME_W+1)'(i_delay_us);
                    n_nres = '0;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_st = ST_DONE; n_ot = '0; n_tv = '0; n_ol = 1'b1;
                unique case (r_op)
                    OP_INSERT: begin
                        if (r_cnt >= CNT_W'(QUEUE_DEPTH)) begin
                            n_st = ST_FULL; n_state = S_OUT;
                        end else begin
                            n_cur.deadline = r_sum[TIME_W] ? {TIME_W{1'b1}} : r_sum[TIME_W-1:0];
                            n_cur.tag = r_tag;
                            o_we = 1'b1; o_addr = r_cnt[ADDR_W-1:0];
                            o_wdata = n_cur;
                            n_pos = r_cnt[ADDR_W-1:0];
                            n_cnt = r_cnt + CNT_W'(1);
                            n_swapped = 1'b0;
                            n_up_only = 1'b0;
                            n_after_exp = 1'b0;
                            n_state = S_UP_RD;
                        end
                    end
                    OP_EXPIRE: begin
                        n_state = S_EXP_RD;
                    end
                    OP_REMOVE: begin
                        n_pos = '0;
                        n_child = '0;
                        n_state = S_SCAN_RD;
                    end
                    default: begin
                        if (r_cnt == '0) begin
                            n_st = ST_NONE; n_state = S_OUT;
                        end else begin
                            o_addr = '0; n_state = S_PEEK_WAIT;
                        end
                    end
                endcase
            end
            S_PEEK_WAIT: begin
                n_tv = TV_W'(i_rdata.deadline);
                n_state = S_OUT;
            end
            // sift-up: r_cur sits at r_pos
            S_UP_RD: begin
                if (r_pos == '0 || {1'b0, r_pos} >= r_cnt) begin
                    n_state = S_UP_SIB_CMP;
                end else begin
                    o_addr = w_par; n_state = S_UP_WAIT;
                end
            end
            S_UP_WAIT: begin
                n_oth = i_rdata; n_oth_idx = w_par; n_state = S_UP_CMP;
            end
            S_UP_CMP: begin
                if (w_lt) begin
                    o_we = 1'b1; o_addr = r_pos; o_wdata = r_oth;
                    n_from = r_pos; n_pos = r_oth_idx; n_swapped = 1'b1;
                    if (r_oth_idx == '0) begin
                        n_state = S_UP_SIB_RD;
                    end else begin
                        n_state = S_UP_RD;
                    end
                end else begin
                    o_we = r_swapped; o_addr = r_pos; o_wdata = r_cur;
                    n_state = r_swapped ? S_UP_SIB_RD : S_UP_SIB_CMP;
                end
            end
            S_UP_SIB_RD: begin
                // write final slot of sifted entry, then fetch sibling
                o_we = 1'b1; o_addr = r_pos; o_wdata = r_cur;
                n_from = r_from[0] ? r_from + ADDR_W'(1) : r_from - ADDR_W'(1);
                if ((r_from[0] ? {1'b0, r_from} + (ADDR_W+1)'(1)
                               : {1'b0, r_from} - (ADDR_W+1)'(1)) >= r_cnt) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_UP_SIB_WAIT;
                end
            end
            S_UP_SIB_WAIT: begin
                o_addr = r_from; n_state = S_UP_SIB_CMP; n_swapped = 1'b1;
            end
            S_UP_SIB_CMP: begin
                if (!r_swapped) begin
                    // no upward move: remove falls through to sift-down
                    n_state = r_up_only ? S_DN_RD : S_OUT;
                end else begin
                    n_swapped = 1'b0;
                    if (w_lt) begin
                        o_we = 1'b1; o_addr = r_pos; o_wdata = i_rdata;
                        n_oth = r_cur; n_cur = r_cur;
                        n_pos = r_from; n_up_only = 1'b0;
                        n_state = S_REM_FILL;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_REM_FILL: begin
                // sibling slot takes the swapped entry, then sift it down
                o_we = 1'b1; o_addr = r_pos; o_wdata = r_oth;
                n_state = S_DN_RD;
            end
            // sift-down: r_cur belongs at r_pos, slot memory may be stale
            S_DN_RD: begin
                if (w_lc >= (ADDR_W+2)'(r_cnt)) begin
                    o_we = 1'b1; o_addr = r_pos; o_wdata = r_cur;
                    n_state = r_after_exp ? S_EXP_RD : S_OUT;
                end else begin
                    o_addr = w_lc[ADDR_W-1:0];
                    n_child = w_lc[ADDR_W:0];
                    n_state = S_DN_WAIT;
                end
            end
            S_DN_WAIT: begin
                n_oth = i_rdata; n_oth_idx = r_child[ADDR_W-1:0];
                if (r_child + (ADDR_W+1)'(1) < (ADDR_W+1)'(r_cnt)) begin
                    o_addr = r_child[ADDR_W-1:0] + ADDR_W'(1);
                    n_state = S_DN_CMP2;
                end else begin
                    n_state = S_DN_CMP;
                end
            end
            S_DN_CMP2: begin
                if (w_lt) begin
                    n_oth = i_rdata; n_oth_idx = r_oth_idx + ADDR_W'(1);
                end
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (w_lt) begin
                    o_we = 1'b1; o_addr = r_pos; o_wdata = r_cur;
                    n_state = r_after_exp ? S_EXP_RD : S_OUT;
                end else begin
                    o_we = 1'b1; o_addr = r_pos; o_wdata = r_oth;
                    n_pos = r_oth_idx;
                    n_state = S_DN_RD;
                end
            end
            // expire loop: each popped tag is held until the next root is checked
            S_EXP_RD: begin
                if (!r_ov || !i_stall) begin
                    if (r_nres == RES_W'(MAX_RESULTS) || r_cnt == '0) begin
                        if (r_nres == '0) begin
                            n_st = ST_NONE; n_ot = '0; n_tv = '0; n_ol = 1'b1;
                            n_state = S_OUT;
                        end else begin
                            n_ov = 1'b1; n_st = ST_EXPIRED; n_ot = TAGF_W'(r_ptag);
                            n_tv = '0; n_ol = 1'b1;
                            n_state = S_IDLE;
                        end
                    end else begin
                        o_addr = '0; n_state = S_EXP_WAIT;
                    end
                end
            end
            S_EXP_WAIT: begin
                n_oth = i_rdata; n_state = S_EXP_CHK;
            end
            S_EXP_CHK: begin
                // output register is free here, it was drained in S_EXP_RD
                if (w_lt) begin
                    if (r_nres == '0) begin
                        n_st = ST_NONE; n_ot = '0; n_tv = '0; n_ol = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        n_ov = 1'b1; n_st = ST_EXPIRED; n_ot = TAGF_W'(r_ptag);
                        n_tv = '0; n_ol = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    if (r_nres != '0) begin
                        n_ov = 1'b1; n_st = ST_EXPIRED; n_ot = TAGF_W'(r_ptag);
                        n_tv = '0; n_ol = 1'b0;
                    end
                    n_cnt = r_cnt - CNT_W'(1);
                    n_nres = r_nres + RES_W'(1);
                    o_addr = n_cnt[ADDR_W-1:0];
                    n_state = S_EXP_LAST_WAIT;
                end
            end
            S_EXP_LAST_WAIT: begin
                n_ptag = r_oth.tag;
                n_cur = i_rdata; n_pos = '0; n_after_exp = 1'b1;
                n_state = (r_cnt == '0) ? S_EXP_RD : S_DN_RD;
            end
            // remove: scan for the first tag match
            S_SCAN_RD: begin
                if (r_child >= (ADDR_W+1)'(r_cnt)) begin
                    n_st = ST_NOTAG; n_state = S_OUT;
                end else begin
                    o_addr = r_child[ADDR_W-1:0]; n_state = S_SCAN_WAIT;
                end
            end
            S_SCAN_WAIT: begin
                n_oth = i_rdata; n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (r_oth.tag == r_tag) begin
                    n_ot = TAGF_W'(r_oth.tag);
                    n_tv = TV_W'({1'b0, r_oth.deadline} - {1'b0, r_now});
                    n_cnt = r_cnt - CNT_W'(1);
                    n_pos = r_child[ADDR_W-1:0];
                    if (r_child == (ADDR_W+1)'(n_cnt)) begin
                        n_state = S_OUT;
                    end else begin
                        o_addr = n_cnt[ADDR_W-1:0];
                        n_state = S_REM_LAST_WAIT;
                    end
                end else begin
                    n_child = r_child + (ADDR_W+1)'(1);
                    n_state = S_SCAN_RD;
                end
            end
            S_REM_LAST_WAIT: begin
                n_cur = i_rdata;
                o_we = 1'b1; o_addr = r_pos; o_wdata = i_rdata;
                n_swapped = 1'b0;
                n_up_only = 1'b1; n_after_exp = 1'b0;
                n_state = S_UP_RD;
            end
            S_OUT: begin
                if (!r_ov || !i_stall) begin
                    n_ov = 1'b1; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // a remove whose sift-up made no swap clears r_up_only as it goes to sift-down
        if (r_state == S_UP_SIB_CMP && !r_swapped && r_up_only) begin
            n_up_only = 1'b0;
        end
    end
endmodule
`default_nettype wire

[rtl/timer_deadline_heap_unit.sv]
// ----------------------------------------------------------------------------
// timer_deadline_heap_unit
// binary min-heap of pending timers kept in a single-port ram
// ----------------------------------------------------------------------------
// input channel: i_valid / o_stall carries opcode, tag, delay and current time.
// output channel: o_valid / i_stall carries status, tag, time value and last.
// one item is worked on at a time; o_stall stays high until the item is done
// and its last result has left the output register.
// every ram access is an address step and a registered read through the
// single ram port, and the one comparator decides each heap step.
// insert: writes the new entry at the end and climbs toward the root; after
// a climb, a sibling recheck and a possible sift-down follow. full queue:
// returns a full status. expire: pops each due timer from the root and sifts
// the last entry down, up to 64 results; each result leaves once the next
// root has been checked. remove: scans the slots for the tag, then a sift.
// peek: reads the root. results leave through one output register; a stall
// from the receiver holds that register and pauses the sequencer.
// reset empties the queue (entry count to zero); ram contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module timer_deadline_heap_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [1:0]                    i_opcode,
    input  wire logic [tdh_pkg::TAGF_W-1:0]    i_tag,
    input  wire logic [tdh_pkg::DELAY_W-1:0]   i_delay_us,
    input  wire logic [tdh_pkg::TIME_W-1:0]    i_now_us,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [2:0]                         o_status,
    output logic [tdh_pkg::TAGF_W-1:0]         o_tag_out,
    output logic signed [tdh_pkg::TV_W-1:0]    o_time_value,
    output logic                               o_last
);
    import tdh_pkg::*;

    logic              w_we;
    logic [ADDR_W-1:0] w_addr;
    t_entry            w_wdata, w_rdata;

    tdh_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_opcode, .i_tag, .i_delay_us,
        .i_now_us, .o_valid, .i_stall, .o_status, .o_tag_out, .o_time_value,
        .o_last, .o_we(w_we), .o_addr(w_addr), .o_wdata(w_wdata), .i_rdata(w_rdata)
    );

    tdh_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_ram (
        .i_clk, .i_we(w_we), .i_addr(w_addr), .i_wdata(w_wdata), .o_rdata(w_rdata)
    );
endmodule
`default_nettype wire

[rtl/tdh_checker.sv]
// ----------------------------------------------------------------------------
// tdh_checker
// port-level checks for the timer deadline heap unit
// ----------------------------------------------------------------------------
`default_nettype none
`include "timer_deadline_heap_unit_macros.svh"
module tdh_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [2:0]  o_status,
    input wire logic        o_last
);
    import tdh_pkg::*;

    `TDH_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    `TDH_ASSERT_IMP(a_status_range, i_clk, i_rst_n, o_valid, o_status <= ST_NONE)
    `TDH_ASSERT_IMP(a_single_last, i_clk, i_rst_n,
        o_valid && (o_status != ST_EXPIRED), o_last)
    `TDH_ASSERT_NXT(a_hold_stalled, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_status))
endmodule

bind timer_deadline_heap_unit tdh_checker u_tdh_checker (
    .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall, .o_status, .o_last
);
`default_nettype wire

[tb/tb_timer_deadline_heap_unit.sv]
// ----------------------------------------------------------------------------
// tb_timer_deadline_heap_unit
// self-checking bench for the timer deadline heap unit
// ----------------------------------------------------------------------------
// a behavioural copy of the heap inside a scoreboard class predicts every
// result item from the accepted input items. directed corner items come
// first, then random insert/expire/remove/peek traffic with bursty input,
// random output stalls and two long output holds that back the unit up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_timer_deadline_heap_unit;
    import tdh_pkg::*;

    typedef struct packed {
        t_status           status;
        logic [TAGF_W-1:0] tag;
        logic [TV_W-1:0]   tv;
        logic              last;
    } t_timer_result;

    class timer_heap_scoreboard;
        logic [TIME_W-1:0]   deadline_q[QUEUE_DEPTH];
        logic [TAG_BITS-1:0] tag_q[QUEUE_DEPTH];
        int                  fill;
        t_timer_result       due_results[$];
        int                  mismatches;
        int                  checked;
        int                  full_hits;
        int                  not_found;
        int                  overdue_removes;
        int                  max_popped;

        function new();
            fill = 0;
            mismatches = 0;
            checked = 0;
            full_hits = 0;
            not_found = 0;
            overdue_removes = 0;
            max_popped = 0;
        endfunction

        function bit earlier(int x, int y);
            return deadline_q[x] < deadline_q[y];
        endfunction

        function void swap_slots(int x, int y);
            logic [TIME_W-1:0]   d;
            logic [TAG_BITS-1:0] t;
            d = deadline_q[x];
            t = tag_q[x];
            deadline_q[x] = deadline_q[y];
            tag_q[x] = tag_q[y];
            deadline_q[y] = d;
            tag_q[y] = t;
        endfunction

        function void sink(int p);
            int c;
            forever begin
                c = 2 * p + 1;
                if (c >= fill) break;
                if (c + 1 < fill && earlier(c + 1, c)) c = c + 1;
                if (earlier(p, c)) break;
                swap_slots(p, c);
                p = c;
            end
        endfunction

        // climbs while strictly earlier, then rechecks the vacated child's sibling
        function bit rise(int p);
            int from;
            int par;
            if (p == 0 || p >= fill) return 0;
            if (!earlier(p, (p - 1) / 2)) return 0;
            swap_slots(p, (p - 1) / 2);
            from = p;
            p = (p - 1) / 2;
            while (p != 0 && earlier(p, (p - 1) / 2)) begin
                par = (p - 1) / 2;
                swap_slots(p, par);
                from = p;
                p = par;
            end
            from = (from % 2 == 1) ? from + 1 : from - 1;
            if (from < fill && earlier(from, p)) begin
                swap_slots(from, p);
                sink(from);
            end
            return 1;
        endfunction

        function void push_result(t_status st, logic [TAGF_W-1:0] tg, logic [TV_W-1:0] tv,
                                  logic lst);
            t_timer_result r;
            r.status = st;
            r.tag = tg;
            r.tv = tv;
            r.last = lst;
            due_results.push_back(r);
        endfunction

        function void note_item(t_op op, logic [TAGF_W-1:0] tg_in, logic [DELAY_W-1:0] dly,
                                logic [TIME_W-1:0] now);
            logic [TIME_W:0]     sum;
            logic [TAG_BITS-1:0] tg;
            int                  n;
            int                  e;
            tg = tg_in[TAG_BITS-1:0];
            case (op)
                OP_INSERT: begin
                    if (fill >= QUEUE_DEPTH) begin
                        full_hits++;
                        push_result(ST_FULL, '0, '0, 1'b1);
                    end else begin
                        sum = {1'b0, now} + {{(TIME_W + 1 - DELAY_W){1'b0}}, dly};
                        deadline_q[fill] = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
                        tag_q[fill] = tg;
                        fill++;
                        void'(rise(fill - 1));
                        push_result(ST_DONE, '0, '0, 1'b1);
                    end
                end
                OP_EXPIRE: begin
                    n = 0;
                    while (n < MAX_RESULTS && fill > 0 && deadline_q[0] <= now) begin
                        push_result(ST_EXPIRED, TAGF_W'(tag_q[0]), '0, 1'b0);
                        fill--;
                        if (fill > 0) begin
                            deadline_q[0] = deadline_q[fill];
                            tag_q[0] = tag_q[fill];
                            sink(0);
                        end
                        n++;
                    end
                    if (n == 0) push_result(ST_NONE, '0, '0, 1'b1);
                    else due_results[$].last = 1'b1;
                    if (n > max_popped) max_popped = n;
                end
                OP_REMOVE: begin
                    for (e = 0; e < fill; e++)
                        if (tag_q[e] == tg) break;
                    if (e >= fill) begin
                        not_found++;
                        push_result(ST_NOTAG, '0, '0, 1'b1);
                    end else begin
                        if (deadline_q[e] < now) overdue_removes++;
                        push_result(ST_DONE, TAGF_W'(tag_q[e]),
                                    {1'b0, deadline_q[e]} - {1'b0, now}, 1'b1);
                        fill--;
                        if (e != fill) begin
                            deadline_q[e] = deadline_q[fill];
                            tag_q[e] = tag_q[fill];
                            if (!rise(e)) sink(e);
                        end
                    end
                end
                default: begin
                    if (fill == 0) push_result(ST_NONE, '0, '0, 1'b1);
                    else push_result(ST_DONE, '0, {1'b0, deadline_q[0]}, 1'b1);
                end
            endcase
        endfunction

        function void check_result(t_timer_result got);
            t_timer_result want;
            checked++;
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: status %0d tag %0h tv %0h last %0b",
                             got.status, got.tag, got.tv, got.last);
                return;
            end
            want = due_results.pop_front();
            if (got != want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: want status %0d tag %0h tv %0h last %0b, ",
                              "got status %0d tag %0h tv %0h last %0b"},
                             want.status, want.tag, want.tv, want.last,
                             got.status, got.tag, got.tv, got.last);
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [1:0]           i_opcode;
    logic [TAGF_W-1:0]    i_tag;
    logic [DELAY_W-1:0]   i_delay_us;
    logic [TIME_W-1:0]    i_now_us;
    logic                 o_valid;
    logic                 i_stall;
    logic [2:0]           o_status;
    logic [TAGF_W-1:0]    o_tag_out;
    logic signed [TV_W-1:0] o_time_value;
    logic                 o_last;

    timer_heap_scoreboard timers;
    int                   burst_left;
    logic [TIME_W-1:0]    clock_now;
    int                   op_count[4];

    timer_deadline_heap_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_opcode     (i_opcode),
        .i_tag        (i_tag),
        .i_delay_us   (i_delay_us),
        .i_now_us     (i_now_us),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_tag_out    (o_tag_out),
        .o_time_value (o_time_value),
        .o_last       (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

    // observe both handshakes with pre-edge values
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            timers.note_item(t_op'(i_opcode), i_tag, i_delay_us, i_now_us);
        if (i_rst_n && o_valid && !i_stall)
            timers.check_result({t_status'(o_status), o_tag_out, o_time_value, o_last});
    end

    // output stall pattern, with two long holds to back the unit up
    initial begin
        int cyc;
        int mode;
        int run;
        i_stall <= 1'b0;
        cyc = 0;
        forever begin
            mode = $urandom_range(0, 3);
            run = $urandom_range(5, 60);
            if (cyc > 3000 && cyc < 3100 || cyc > 40000 && cyc < 40100) begin
                i_stall <= 1'b1;
                repeat (800) @(posedge i_clk);
                cyc += 800;
            end
            repeat (run) begin
                @(posedge i_clk);
                cyc++;
                case (mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 1) == 1);
                    2: i_stall <= ($urandom_range(0, 7) == 0);
                    default: i_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    task automatic send_item(t_op op, logic [TAGF_W-1:0] tg, logic [DELAY_W-1:0] dly,
                             logic [TIME_W-1:0] now);
        i_valid <= 1'b1;
        i_opcode <= op;
        i_tag <= tg;
        i_delay_us <= dly;
        i_now_us <= now;
        op_count[op]++;
        do @(posedge i_clk); while (!(i_valid && !o_stall));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        end
    endtask

    function automatic logic [TAGF_W-1:0] pick_tag();
        if ($urandom_range(0, 99) < 85) return TAGF_W'($urandom_range(0, 23));
        return TAGF_W'($urandom_range(0, 65535));
    endfunction

    task automatic random_item(int ins_weight);
        int                 r;
        logic [DELAY_W-1:0] dly;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0) clock_now = TIME_W'({$urandom, $urandom});
        else clock_now = clock_now + TIME_W'($urandom_range(0, 1500));
        if ($urandom_range(0, 9) == 0) dly = DELAY_W'({$urandom, $urandom});
        else dly = DELAY_W'($urandom_range(0, 4000));
        if (r < ins_weight) send_item(OP_INSERT, pick_tag(), dly, clock_now);
        else if (r < ins_weight + (100 - ins_weight) / 3)
            send_item(OP_EXPIRE, pick_tag(), dly, clock_now);
        else if (r < ins_weight + 2 * (100 - ins_weight) / 3)
            send_item(OP_REMOVE, pick_tag(), dly, clock_now);
        else send_item(OP_PEEK, pick_tag(), dly, clock_now);
    endtask

    initial begin
        int k;
        timers = new();
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_opcode <= OP_PEEK;
        i_tag <= '0;
        i_delay_us <= '0;
        i_now_us <= '0;
        burst_left = 0;
        clock_now = 52'd1000;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty queue corners
        send_item(OP_PEEK, 16'h0, '0, '0);
        send_item(OP_EXPIRE, 16'h0, '0, {TIME_W{1'b1}});
        send_item(OP_REMOVE, 16'hFFFF, '0, '0);
        // saturating deadline, zero delay, equal deadlines
        send_item(OP_INSERT, 16'hFFFF, {DELAY_W{1'b1}}, {TIME_W{1'b1}});
        send_item(OP_INSERT, 16'h0, '0, 52'd500);
        send_item(OP_INSERT, 16'h5, 40'd100, 52'd400);
        send_item(OP_INSERT, 16'h6, 40'd100, 52'd400);
        send_item(OP_INSERT, 16'h7, 40'd50, 52'd450);
        send_item(OP_PEEK, 16'h0, {DELAY_W{1'b1}}, 52'd500);
        send_item(OP_EXPIRE, 16'h0, '0, 52'd100);
        // overdue removal gives a negative time left
        send_item(OP_REMOVE, 16'h6, '0, 52'd900);
        send_item(OP_REMOVE, 16'h1234, '0, 52'd900);
        send_item(OP_EXPIRE, 16'h0, '0, 52'd500);
        send_item(OP_REMOVE, 16'hFFFF, '0, 52'd10);
        send_item(OP_PEEK, 16'hAAAA, 40'h55_5555_5555, 52'hA_AAAA_AAAA_AAAA);
        send_item(OP_INSERT, 16'h8, 40'h80_0000_0000, 52'h8_0000_0000_0000);
        send_item(OP_EXPIRE, 16'h0, '0, {TIME_W{1'b1}});
        send_item(OP_EXPIRE, 16'h0, '0, {TIME_W{1'b1}});

        for (k = 0; k < 300; k++) begin
            // an insert-heavy stretch fills the queue, then a big jump drains it
            if (k >= 60 && k < 150) random_item(92);
            else random_item(40);
            if (k == 150) begin
                clock_now = clock_now + 52'd10_000_000;
                send_item(OP_EXPIRE, '0, '0, clock_now);
            end
        end

        i_valid <= 1'b0;
        while (timers.due_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("ran %0d inserts, %0d expires, %0d removes, %0d peeks; %0d results checked",
                 op_count[OP_INSERT], op_count[OP_EXPIRE], op_count[OP_REMOVE],
                 op_count[OP_PEEK], timers.checked);
        $display("queue full %0d times, most timers popped at once %0d, %0d misses, %0d overdue",
                 timers.full_hits, timers.max_popped, timers.not_found,
                 timers.overdue_removes);
        if (timers.mismatches == 0 && timers.due_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", timers.mismatches);
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire
